@@ design/skl_pkg.sv @@
// shared types and constants for the sorted key lookup-or-insert table
package skl_pkg;

  localparam int KEY_W     = 32;
  localparam int HANDLE_W  = 6;
  localparam int ENTRIES_W = 7;
  localparam int FAN_IN    = 8;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // control broadcast from the sequencer to every table cell
  typedef struct packed {
    logic                    cmp_en;
    logic                    upd_en;
    logic signed [KEY_W-1:0] key;
  } skl_cell_ctrl_t;

endpackage

@@ design/skl_if.sv @@
// request and response channel interfaces of the sorted key table

interface skl_req_if import skl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

interface skl_rsp_if import skl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [HANDLE_W-1:0]  handle;
  logic                 created;
  logic                 full_res;
  logic [ENTRIES_W-1:0] entries;

  modport source (output valid, output handle, output created, output full_res,
                  output entries, input ready);
  modport sink (input valid, input handle, input created, input full_res,
                input entries, output ready);
endinterface

@@ design/skl_cell.sv @@
// one table slot: holds a key and handle, compares, and shifts up on insert
module skl_cell import skl_pkg::*; #(
  parameter int HW = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  skl_cell_ctrl_t          ctrl_i,
  input  logic [HW-1:0]           new_handle_i,
  input  logic                    in_use_i,
  input  logic signed [KEY_W-1:0] left_key_i,
  input  logic [HW-1:0]           left_handle_i,
  input  logic                    left_ins_i,
  output logic signed [KEY_W-1:0] key_o,
  output logic [HW-1:0]           handle_o,
  output logic                    ins_o,
  output logic                    hit_o
);

  logic signed [KEY_W-1:0] key_q;
  logic [HW-1:0]           handle_q;
  logic                    ins_q, ins_d;
  logic                    hit_q, hit_d;

  // local compare: slot matches, or slot sits at or above the insert point
  assign hit_d = in_use_i && (key_q == ctrl_i.key);
  assign ins_d = !in_use_i || (key_q > ctrl_i.key);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q <= 1'b0;
      hit_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      ins_q <= ins_d;
      hit_q <= hit_d;
    end
  end

  // insert point takes the new key, slots above it take their left neighbor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd_en && ins_q) begin
      if (!left_ins_i) begin
        key_q    <= ctrl_i.key;
        handle_q <= new_handle_i;
      end else begin
        key_q    <= left_key_i;
        handle_q <= left_handle_i;
      end
    end
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;
  assign ins_o    = ins_q;
  assign hit_o    = hit_q;

endmodule

@@ design/skl_or_tree.sv @@
// one registered level of the hit reduction tree, eight inputs per node
module skl_or_tree import skl_pkg::*; #(
  parameter int N  = 64,
  parameter int HW = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [N-1:0]                  hit_i,
  input  logic [N-1:0][HW-1:0]          hnd_i,
  output logic [(N+FAN_IN-1)/FAN_IN-1:0] hit_o,
  output logic [(N+FAN_IN-1)/FAN_IN-1:0][HW-1:0] hnd_o
);

  localparam int NO = (N + FAN_IN - 1) / FAN_IN;

  logic [NO*FAN_IN-1:0]          hit_pad;
  logic [NO*FAN_IN-1:0][HW-1:0]  hnd_pad;
  logic [NO-1:0]                 hit_d, hit_q;
  logic [NO-1:0][HW-1:0]         hnd_d, hnd_q;

  // pad to whole nodes and mask handles of slots that did not match
  for (genvar g = 0; g < NO * FAN_IN; g++) begin : g_pad
    if (g < N) begin : g_real
      assign hit_pad[g] = hit_i[g];
      assign hnd_pad[g] = hnd_i[g] & {HW{hit_i[g]}};
    end else begin : g_zero
      assign hit_pad[g] = 1'b0;
      assign hnd_pad[g] = '0;
    end
  end

  // at most one slot matches, so an or of masked handles selects it
  for (genvar j = 0; j < NO; j++) begin : g_node
    always_comb begin
      hit_d[j] = |hit_pad[j*FAN_IN +: FAN_IN];
      hnd_d[j] = '0;
      for (int k = 0; k < FAN_IN; k++) begin
        hnd_d[j] = hnd_d[j] | hnd_pad[j*FAN_IN + k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hnd_q <= hnd_d;
  end

  assign hit_o = hit_q;
  assign hnd_o = hnd_q;

endmodule

@@ design/sorted_key_lookup_or_insert.sv @@
// top level: sorted key table built as a chain of cells with lookup-or-insert
// A request passes the compare state, the LEVELS = ceil(log8(CAPACITY)) registered levels
// of the hit tree and the commit state, which waits until the output register is free;
// one request is in work at a time, and the next is taken while the previous result
// still waits in the output register.
// Reset (asynchronous, active low) empties the table and drops the output.
module sorted_key_lookup_or_insert import skl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skl_req_if.sink   req_i,
  skl_rsp_if.source rsp_o
);

  localparam int HW     = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = ($clog2(CAPACITY) + 2) / 3;
  localparam int LW     = $clog2(LEVELS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CMP    = 2'd1;
  localparam logic [1:0] ST_RED    = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  // number of nodes at a given tree level
  function automatic int lvl_n(input int l);
    int n;
    n = CAPACITY;
    for (int i = 0; i < l; i++) begin
      n = (n + FAN_IN - 1) / FAN_IN;
    end
    return n;
  endfunction

  logic [1:0]              state_q, state_d;
  logic [LW-1:0]           red_cnt_q, red_cnt_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    cmd_q;
  logic signed [KEY_W-1:0] key_q;

  logic                    out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0]     out_handle_q, out_handle_d;
  logic                    out_created_q, out_created_d;
  logic                    out_full_q, out_full_d;
  logic [ENTRIES_W-1:0]    out_entries_q, out_entries_d;

  logic                    req_fire;
  logic                    out_free;
  logic                    commit;
  logic                    tree_hit;
  logic [HW-1:0]           tree_hnd;
  logic                    do_insert;
  skl_cell_ctrl_t          ctrl;

  logic signed [KEY_W-1:0]                cell_key [CAPACITY];
  logic [CAPACITY-1:0]                    cell_ins;
  logic [LEVELS:0][CAPACITY-1:0]          hit_lv;
  logic [LEVELS:0][CAPACITY-1:0][HW-1:0]  hnd_lv;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign commit   = (state_q == ST_COMMIT) && out_free;
  assign tree_hit = hit_lv[LEVELS][0];
  assign tree_hnd = hnd_lv[LEVELS][0];
  assign do_insert = commit && (cmd_q == CMD_LOOKUP) && !tree_hit
                     && (count_q != CW'(CAPACITY));

  assign ctrl.cmp_en = (state_q == ST_CMP);
  assign ctrl.upd_en = do_insert;
  assign ctrl.key    = key_q;

  // chain of table cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key;
    logic [HW-1:0]           left_hnd;
    logic                    left_ins;
    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_hnd = '0;
      assign left_ins = 1'b0;
    end else begin : g_rest
      assign left_key = cell_key[i-1];
      assign left_hnd = hnd_lv[0][i-1];
      assign left_ins = cell_ins[i-1];
    end
    skl_cell #(.HW(HW)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_handle_i  (count_q[HW-1:0]),
      .in_use_i      (count_q > CW'(i)),
      .left_key_i    (left_key),
      .left_handle_i (left_hnd),
      .left_ins_i    (left_ins),
      .key_o         (cell_key[i]),
      .handle_o      (hnd_lv[0][i]),
      .ins_o         (cell_ins[i]),
      .hit_o         (hit_lv[0][i])
    );
  end

  // registered reduction of per-cell hits down to one hit and handle
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int NI = lvl_n(l);
    localparam int NO = lvl_n(l + 1);
    skl_or_tree #(.N(NI), .HW(HW)) u_tree (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .hit_i  (hit_lv[l][NI-1:0]),
      .hnd_i  (hnd_lv[l][NI-1:0]),
      .hit_o  (hit_lv[l+1][NO-1:0]),
      .hnd_o  (hnd_lv[l+1][NO-1:0])
    );
    if (NO < CAPACITY) begin : g_tie
      assign hit_lv[l+1][CAPACITY-1:NO] = '0;
      assign hnd_lv[l+1][CAPACITY-1:NO] = '0;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    red_cnt_d = red_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d   = ST_RED;
        red_cnt_d = '0;
      end
      ST_RED: begin
        if (red_cnt_q == LW'(LEVELS - 1)) begin
          state_d = ST_COMMIT;
        end else begin
          red_cnt_d = red_cnt_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result and entry count at commit
  always_comb begin
    count_d       = count_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_handle_d  = out_handle_q;
    out_created_d = out_created_q;
    out_full_d    = out_full_q;
    out_entries_d = out_entries_q;
    if (commit) begin
      out_valid_d   = 1'b1;
      out_handle_d  = '0;
      out_created_d = 1'b0;
      out_full_d    = 1'b0;
      priority if (cmd_q == CMD_CLEAR) begin
        count_d = '0;
      end else if (tree_hit) begin
        out_handle_d = HANDLE_W'(tree_hnd);
      end else if (count_q == CW'(CAPACITY)) begin
        out_full_d = 1'b1;
      end else begin
        out_handle_d  = HANDLE_W'(count_q[HW-1:0]);
        out_created_d = 1'b1;
        count_d       = count_q + 1'b1;
      end
      out_entries_d = ENTRIES_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      red_cnt_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      red_cnt_q   <= red_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture and output payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key;
    end
    out_handle_q  <= out_handle_d;
    out_created_q <= out_created_d;
    out_full_q    <= out_full_d;
    out_entries_q <= out_entries_d;
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.handle   = out_handle_q;
  assign rsp_o.created  = out_created_q;
  assign rsp_o.full_res = out_full_q;
  assign rsp_o.entries  = out_entries_q;

endmodule

@@ design/skl_checker.sv @@
// port-level checks on the sorted key table, bound to the top level
module skl_checker import skl_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid_i,
  input logic                 req_ready_i,
  input logic                 rsp_valid_i,
  input logic                 rsp_ready_i,
  input logic [HANDLE_W-1:0]  rsp_handle_i,
  input logic                 rsp_created_i,
  input logic                 rsp_full_i,
  input logic [ENTRIES_W-1:0] rsp_entries_i
);

  // a new entry takes the handle equal to the count before the insert
  a_created_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_created_i |-> rsp_handle_i == HANDLE_W'(rsp_entries_i - 1'b1))
    else $error("created handle does not follow entry count");

  // a full table reports no handle and no insert
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_full_i |-> !rsp_created_i && rsp_handle_i == '0)
    else $error("full result with handle or insert");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_handle_i)
      && $stable(rsp_created_i) && $stable(rsp_full_i) && $stable(rsp_entries_i))
    else $error("stalled response changed");

endmodule

bind sorted_key_lookup_or_insert skl_checker u_skl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_handle_i  (rsp_o.handle),
  .rsp_created_i (rsp_o.created),
  .rsp_full_i    (rsp_o.full_res),
  .rsp_entries_i (rsp_o.entries)
);

@@ dv/tb_top.sv @@
// testbench for the sorted key table: lookup, insert, full and clear against a table model
`timescale 1ns / 100ps

module tb_top import skl_pkg::*; ();

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 20;
  localparam int RAND_ITEMS  = 800;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic                 created;
    logic                 full_res;
    logic [ENTRIES_W-1:0] entries;
  } skl_rsp_t;

  typedef struct {
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
    bit                      wait_idle;
  } skl_req_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_EVERY3
  } rdy_mode_e;

  logic clk_i;
  logic rst_ni;

  skl_req_if req_if ();
  skl_rsp_if rsp_if ();

  sorted_key_lookup_or_insert #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // table model state
  logic signed [KEY_W-1:0] tbl_key [CAPACITY];
  logic [HANDLE_W-1:0]     tbl_hdl [CAPACITY];
  int                      tbl_cnt = 0;

  // requests waiting to go out and responses still due
  skl_req_t pend_q[$];
  skl_rsp_t due_rsp_q[$];

  // keys the generator knows to be in the table
  logic signed [KEY_W-1:0] gen_keys[$];

  int n_acc = 0;
  int n_rcv = 0;
  int n_err = 0;
  int n_clear = 0;
  int n_insert = 0;
  int n_hit = 0;
  int n_full = 0;
  int n_idle_waits = 0;
  int cycles = 0;

  // lookup-or-insert on the model table, returns the response it owes
  function automatic skl_rsp_t table_lookup_insert(logic cmd, logic signed [KEY_W-1:0] key);
    skl_rsp_t r;
    int lo;
    int hi;
    int mid;
    bit hit;
    r = '0;
    lo = 0;
    hi = tbl_cnt;
    hit = 1'b0;
    if (cmd == CMD_CLEAR) begin
      tbl_cnt = 0;
    end else begin
      while (lo < hi && !hit) begin
        mid = (lo + hi) / 2;
        if (key == tbl_key[mid]) begin
          r.handle = tbl_hdl[mid];
          hit = 1'b1;
        end else if (key < tbl_key[mid]) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      if (!hit) begin
        if (tbl_cnt >= CAPACITY) begin
          r.full_res = 1'b1;
        end else begin
          // shift larger entries up to open the slot
          for (int i = tbl_cnt; i > lo; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_hdl[i] = tbl_hdl[i-1];
          end
          tbl_key[lo] = key;
          tbl_hdl[lo] = HANDLE_W'(tbl_cnt);
          r.handle    = HANDLE_W'(tbl_cnt);
          r.created   = 1'b1;
          tbl_cnt     = tbl_cnt + 1;
        end
      end
    end
    r.entries = ENTRIES_W'(tbl_cnt);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_err++;
    end
  endfunction

  function automatic bit gen_known(logic signed [KEY_W-1:0] key);
    foreach (gen_keys[i]) begin
      if (gen_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // key mix: present keys, their neighbors, extremes, small and wide values
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] edge_keys[6];
    int sel;
    edge_keys = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                  32'sh8000_0001, 32'sh7fff_fffe};
    sel = $urandom_range(0, 9);
    if (gen_keys.size() > 0 && sel <= 1) begin
      return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    end
    if (gen_keys.size() > 0 && sel == 2) begin
      return gen_keys[$urandom_range(0, gen_keys.size() - 1)] +
             ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
    end
    if (sel == 3) return edge_keys[$urandom_range(0, 5)];
    if (sel == 4) return $signed(KEY_W'($urandom_range(0, 16))) - 32'sd8;
    return $signed(KEY_W'($urandom()));
  endfunction

  task automatic add_req(logic cmd, logic signed [KEY_W-1:0] key, bit wait_idle);
    skl_req_t it;
    it.cmd = cmd;
    it.key = key;
    it.wait_idle = wait_idle;
    pend_q.push_back(it);
    if (wait_idle) n_idle_waits++;
    if (cmd == CMD_CLEAR) begin
      gen_keys.delete();
    end else if (!gen_known(key) && gen_keys.size() < CAPACITY) begin
      gen_keys.push_back(key);
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // request driver: bursts with random gaps, optional wait for an idle block
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin : drive_req
    skl_req_t nxt;
    skl_rsp_t due;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.cmd   <= CMD_LOOKUP;
      req_if.key   <= '0;
      tbl_cnt = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        due = table_lookup_insert(req_if.cmd, req_if.key);
        due_rsp_q.push_back(due);
        n_acc++;
        if (req_if.cmd == CMD_CLEAR) n_clear++;
        else if (due.created) n_insert++;
        else if (due.full_res) n_full++;
        else n_hit++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pend_q.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (pend_q[0].wait_idle && n_rcv < n_acc) begin
          req_if.valid <= 1'b0;
        end else begin
          nxt = pend_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.cmd   <= nxt.cmd;
          req_if.key   <= nxt.key;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
          end
        end
      end
    end
  end

  // response ready: changing stall patterns plus one long hold-off
  rdy_mode_e rdy_mode = RDY_ALWAYS;
  int mode_left = 0;
  int hold_left = 0;
  int phase3 = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 120);
      end else begin
        mode_left--;
      end
      phase3 = (phase3 == 2) ? 0 : phase3 + 1;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && n_rcv >= 150) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        rsp_if.ready <= 1'b0;
      end else begin
        case (rdy_mode)
          RDY_ALWAYS: rsp_if.ready <= 1'b1;
          RDY_COIN:   rsp_if.ready <= ($urandom_range(0, 1) == 1);
          RDY_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          RDY_EVERY3: rsp_if.ready <= (phase3 == 0);
          default:    rsp_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // response monitor: compare with the oldest response due
  always @(posedge clk_i) begin : watch_rsp
    skl_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_rsp_q.size() == 0) begin
        $display("%0t: response with none due, expected nothing, actual handle %0d entries %0d",
                 $time, rsp_if.handle, rsp_if.entries);
        n_err++;
      end else begin
        want = due_rsp_q.pop_front();
        check_field("handle", want.handle, rsp_if.handle);
        check_field("created", want.created, rsp_if.created);
        check_field("full_res", want.full_res, rsp_if.full_res);
        check_field("entries", want.entries, rsp_if.entries);
      end
      n_rcv <= n_rcv + 1;
    end
  end

  // run limit
  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d responses still due",
               $time, cycles, due_rsp_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int n_rand;
    int target;
    int steps;
    logic signed [KEY_W-1:0] k;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_LOOKUP;
    req_if.key = '0;
    rsp_if.ready = 1'b0;

    // directed: clear on empty, extremes, hits, lookups after clear
    add_req(CMD_CLEAR, $signed(KEY_W'($urandom())), 1'b0);
    add_req(CMD_LOOKUP, 32'sh0, 1'b0);
    add_req(CMD_LOOKUP, 32'sh7fff_ffff, 1'b0);
    add_req(CMD_LOOKUP, 32'sh8000_0000, 1'b0);
    add_req(CMD_LOOKUP, -32'sd1, 1'b0);
    add_req(CMD_LOOKUP, 32'sd1, 1'b0);
    add_req(CMD_LOOKUP, 32'sh0, 1'b0);
    add_req(CMD_LOOKUP, 32'sh7fff_ffff, 1'b0);
    add_req(CMD_LOOKUP, 32'sh8000_0000, 1'b0);
    add_req(CMD_LOOKUP, -32'sd1, 1'b0);
    add_req(CMD_LOOKUP, 32'sd1, 1'b0);
    add_req(CMD_CLEAR, 32'sh7fff_ffff, 1'b1);
    add_req(CMD_LOOKUP, 32'sh7fff_ffff, 1'b0);
    add_req(CMD_LOOKUP, 32'sh8000_0000, 1'b0);
    add_req(CMD_LOOKUP, 32'sh7fff_ffff, 1'b0);
    add_req(CMD_CLEAR, 32'sh8000_0000, 1'b0);

    // fill to capacity with descending then random keys, then miss and hit when full
    n_rand = 0;
    for (int i = 0; i < CAPACITY / 2; i++) begin
      add_req(CMD_LOOKUP, 32'sh7fff_ffff - i, 1'b0);
      n_rand++;
    end
    while (gen_keys.size() < CAPACITY) begin
      add_req(CMD_LOOKUP, $signed(KEY_W'($urandom())), 1'b0);
      n_rand++;
    end
    for (int i = 0; i < 8; i++) begin
      add_req(CMD_LOOKUP, pick_key(), 1'b0);
      n_rand++;
    end
    add_req(CMD_CLEAR, $signed(KEY_W'($urandom())), 1'b0);
    n_rand++;

    // random episodes: mostly clear-then-fill sequences, the rest noise
    while (n_rand < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        add_req(CMD_CLEAR, $signed(KEY_W'($urandom())), $urandom_range(0, 3) == 0);
        n_rand++;
        target = ($urandom_range(0, 3) == 0) ? CAPACITY : $urandom_range(1, 24);
        steps = 0;
        while (gen_keys.size() < target && steps < 4 * target) begin
          k = ($urandom_range(0, 1) == 0) ? pick_key() : $signed(KEY_W'($urandom()));
          add_req(CMD_LOOKUP, k, 1'b0);
          n_rand++;
          steps++;
        end
        for (int i = $urandom_range(2, 8); i > 0; i--) begin
          add_req(CMD_LOOKUP, pick_key(), 1'b0);
          n_rand++;
        end
      end else begin
        for (int i = $urandom_range(10, 30); i > 0; i--) begin
          k = pick_key();
          add_req(($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_LOOKUP, k, 1'b0);
          n_rand++;
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every request to go out and every response to come back
    do @(negedge clk_i);
    while (pend_q.size() != 0 || req_if.valid || n_rcv < n_acc);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (due_rsp_q.size() != 0) begin
      $display("%0t: %0d responses never arrived, expected 0 left, actual %0d",
               $time, due_rsp_q.size(), due_rsp_q.size());
      n_err++;
    end

    $display("covered %0d requests: %0d clears, %0d inserts, %0d hits, %0d misses on a full table",
             n_acc, n_clear, n_insert, n_hit, n_full);
    $display("with bursty requests, stalling responses, a %0d-cycle hold-off and %0d idle waits",
             LONG_HOLD, n_idle_waits);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/skl_pkg.sv
design/skl_if.sv
design/skl_cell.sv
design/skl_or_tree.sv
design/sorted_key_lookup_or_insert.sv
design/skl_checker.sv
dv/tb_top.sv
